/* hw/rtl/pdds_pkg.sv */
// ----------------------------------------------------------------------------
// pdds_pkg
// Shared constants and register indexes for the differential drive steering
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdds_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_DIFFERENCE = 3'd0,
        CFG_GAIN_P            = 3'd1,
        CFG_GAIN_I            = 3'd2,
        CFG_GAIN_D            = 3'd3,
        CFG_BASE_SPEED        = 3'd4
    } t_cfg_index;

    localparam logic signed [15:0] TARGET_RESET = 16'sd0;
    localparam logic [15:0]        GAIN_P_RESET = 16'd256;
    localparam logic [15:0]        GAIN_I_RESET = 16'd0;
    localparam logic [15:0]        GAIN_D_RESET = 16'd0;
    localparam logic [7:0]         BASE_RESET   = 8'd128;

    localparam logic signed [17:0] SUM_LIMIT       = 18'sd100;
    localparam logic signed [34:0] CORR_LIMIT_Q8   = 35'sd38400;
    localparam logic signed [16:0] BOOST_THRESHOLD = 17'sd200;
    localparam logic [10:0]        DRIVE_MIN       = 11'd40;
    localparam logic [10:0]        DRIVE_MAX       = 11'd255;
    localparam logic [7:0]         SEARCH_FLOOR    = 8'd45;
    localparam logic [7:0]         SEARCH_DROP     = 8'd15;
    localparam logic [7:0]         SEARCH_OUT_MIN  = DRIVE_MIN[7:0] - SEARCH_DROP;

endpackage

`default_nettype wire

/* hw/rtl/pid_differential_drive_steer.sv */
// ----------------------------------------------------------------------------
// pid_differential_drive_steer
// Wall-following PID steering for a two-wheel drive with track and search
// requests.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while o_in_ready is high. A request
// passes the error and integral stage, the gain multiplier stage and the clamp
// and drive stage that loads the output register; a search request gives a
// result only if a wheel level exceeds the search floor. The pipeline keeps
// accepting while a result waits, until its last stage holds a blocked item.
// Configuration writes are always ready and must be made while the block is
// idle.
`default_nettype none

module pid_differential_drive_steer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_kind,
    input  wire logic signed [15:0]             i_side_difference,
    input  wire logic signed [15:0]             i_gyro_rate,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic             [7:0]              o_left_drive,
    output logic             [7:0]              o_right_drive,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pdds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);
    import pdds_pkg::*;

    logic signed [15:0] r_target;
    logic        [15:0] r_gain_p;
    logic        [15:0] r_gain_i;
    logic        [15:0] r_gain_d;
    logic        [7:0]  r_base;

    logic signed [7:0]  r_error_sum;
    logic        [7:0]  r_left_level;
    logic        [7:0]  r_right_level;

    logic               r_s1_valid;
    logic               r_s1_kind;
    logic               r_s1_boost;
    logic signed [16:0] r_s1_err;
    logic signed [7:0]  r_s1_sum;
    logic signed [15:0] r_s1_gyro;

    logic               r_s2_valid;
    logic               r_s2_kind;
    logic               r_s2_boost;
    logic signed [33:0] r_s2_prod_p;
    logic signed [24:0] r_s2_prod_i;
    logic signed [32:0] r_s2_prod_d;

    logic               r_out_valid;
    logic        [7:0]  r_out_left;
    logic        [7:0]  r_out_right;

    logic               w_out_can;
    logic               w_en;

    logic signed [16:0] w_err;
    logic signed [17:0] w_sum_raw;
    logic signed [7:0]  n_sum;
    logic               w_boost;

    logic signed [33:0] w_prod_p;
    logic signed [24:0] w_prod_i;
    logic signed [32:0] w_prod_d;

    logic signed [34:0] w_c8_raw;
    logic signed [16:0] w_c8;
    logic signed [18:0] w_c9_raw;
    logic        [15:0] w_lim_prod;
    logic signed [18:0] w_lim9;
    logic signed [18:0] w_c9;
    logic signed [19:0] w_base9;
    logic signed [19:0] w_l9;
    logic signed [19:0] w_r9;
    logic signed [10:0] w_l_int;
    logic signed [10:0] w_r_int;
    logic        [7:0]  w_track_left;
    logic        [7:0]  w_track_right;
    logic               w_search_hit;
    logic        [7:0]  w_search_left;
    logic        [7:0]  w_search_right;
    logic               w_res_valid;
    logic        [7:0]  n_out_left;
    logic        [7:0]  n_out_right;

    assign w_out_can   = !r_out_valid || i_out_ready;
    assign w_en        = w_out_can || !r_s2_valid;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_left_drive  = r_out_left;
    assign o_right_drive = r_out_right;

    // Error and clamped integral.
    assign w_err     = 17'(i_side_difference) - 17'(r_target);
    assign w_sum_raw = 18'(r_error_sum) + 18'(w_err);
    assign w_boost   = (w_err > BOOST_THRESHOLD) || (w_err < -BOOST_THRESHOLD);

    always_comb begin
        if (w_sum_raw > SUM_LIMIT) begin
            n_sum = 8'(SUM_LIMIT);
        end else if (w_sum_raw < -SUM_LIMIT) begin
            n_sum = 8'(-SUM_LIMIT);
        end else begin
            n_sum = w_sum_raw[7:0];
        end
    end

    // Gain products.
    assign w_prod_p = $signed({1'b0, r_gain_p}) * r_s1_err;
    assign w_prod_i = $signed({1'b0, r_gain_i}) * r_s1_sum;
    assign w_prod_d = $signed({1'b0, r_gain_d}) * r_s1_gyro;

    // Correction, boost, steering limit and wheel drives.
    assign w_c8_raw = 35'(r_s2_prod_p) + 35'(r_s2_prod_i) - 35'(r_s2_prod_d);

    always_comb begin
        if (w_c8_raw > CORR_LIMIT_Q8) begin
            w_c8 = 17'(CORR_LIMIT_Q8);
        end else if (w_c8_raw < -CORR_LIMIT_Q8) begin
            w_c8 = 17'(-CORR_LIMIT_Q8);
        end else begin
            w_c8 = w_c8_raw[16:0];
        end
    end

    // Four fifths of the base speed, by reciprocal multiplication.
    assign w_lim_prod = 16'(r_base) * 16'd205;
    assign w_lim9     = $signed({2'b00, w_lim_prod[15:8], 9'd0});
    assign w_c9_raw   = (19'(w_c8) <<< 1) + (r_s2_boost ? 19'(w_c8) : 19'sd0);

    always_comb begin
        if (w_c9_raw > w_lim9) begin
            w_c9 = w_lim9;
        end else if (w_c9_raw < -w_lim9) begin
            w_c9 = -w_lim9;
        end else begin
            w_c9 = w_c9_raw;
        end
    end

    assign w_base9 = $signed({3'b000, r_base, 9'd0});
    assign w_l9    = w_base9 + 20'(w_c9);
    assign w_r9    = w_base9 - 20'(w_c9);
    assign w_l_int = w_l9[19:9];
    assign w_r_int = w_r9[19:9];

    always_comb begin
        if (w_l_int < $signed(DRIVE_MIN)) begin
            w_track_left = DRIVE_MIN[7:0];
        end else if (w_l_int > $signed(DRIVE_MAX)) begin
            w_track_left = DRIVE_MAX[7:0];
        end else begin
            w_track_left = w_l_int[7:0];
        end
        if (w_r_int < $signed(DRIVE_MIN)) begin
            w_track_right = DRIVE_MIN[7:0];
        end else if (w_r_int > $signed(DRIVE_MAX)) begin
            w_track_right = DRIVE_MAX[7:0];
        end else begin
            w_track_right = w_r_int[7:0];
        end
    end

    assign w_search_hit   = (r_left_level > SEARCH_FLOOR) || (r_right_level > SEARCH_FLOOR);
    assign w_search_left  = (r_left_level >= SEARCH_DROP) ? r_left_level - SEARCH_DROP : 8'd0;
    assign w_search_right = (r_right_level >= SEARCH_DROP) ? r_right_level - SEARCH_DROP
                                                            : 8'd0;

    always_comb begin
        if (r_s2_kind) begin
            w_res_valid = w_search_hit;
            n_out_left  = w_search_left;
            n_out_right = w_search_right;
        end else begin
            w_res_valid = 1'b1;
            n_out_left  = w_track_left;
            n_out_right = w_track_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= TARGET_RESET;
            r_gain_p      <= GAIN_P_RESET;
            r_gain_i      <= GAIN_I_RESET;
            r_gain_d      <= GAIN_D_RESET;
            r_base        <= BASE_RESET;
            r_error_sum   <= 8'sd0;
            r_left_level  <= 8'd0;
            r_right_level <= 8'd0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TARGET_DIFFERENCE: r_target <= $signed(i_cfg_data);
                    CFG_GAIN_P:            r_gain_p <= i_cfg_data;
                    CFG_GAIN_I:            r_gain_i <= i_cfg_data;
                    CFG_GAIN_D:            r_gain_d <= i_cfg_data;
                    CFG_BASE_SPEED:        r_base   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (w_en) begin
                r_s1_valid <= i_in_valid;
                r_s2_valid <= r_s1_valid;
                if (i_in_valid && !i_kind) begin
                    r_error_sum <= n_sum;
                end
                if (r_s2_valid && !r_s2_kind) begin
                    r_left_level  <= w_track_left;
                    r_right_level <= w_track_right;
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_en && r_s2_valid) begin
                r_out_valid <= w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind   <= i_kind;
            r_s1_boost  <= w_boost;
            r_s1_err    <= w_err;
            r_s1_sum    <= n_sum;
            r_s1_gyro   <= i_gyro_rate;
            r_s2_kind   <= r_s1_kind;
            r_s2_boost  <= r_s1_boost;
            r_s2_prod_p <= w_prod_p;
            r_s2_prod_i <= w_prod_i;
            r_s2_prod_d <= w_prod_d;
            if (r_s2_valid && w_res_valid) begin
                r_out_left  <= n_out_left;
                r_out_right <= n_out_right;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pdds_checker.sv */
// ----------------------------------------------------------------------------
// pdds_checker
// Port-level checks for the differential drive steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pdds_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic             [7:0]         o_left_drive,
    input wire logic             [7:0]         o_right_drive
);
    import pdds_pkg::*;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_left_drive) && $stable(o_right_drive))
        else $error("stalled result changed");

    a_drive_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_drive >= SEARCH_OUT_MIN) && (o_right_drive >= SEARCH_OUT_MIN))
        else $error("drive level below the lowest reachable value");

    a_rise_after_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_ready))
        else $error("result appeared while the pipeline was stalled");

endmodule

bind pid_differential_drive_steer pdds_checker u_pdds_checker (.*);

`default_nettype wire
